// ===== rtl/ssplit_pkg.sv =====
`timescale 1ns / 1ps
package ssplit_pkg;

  // Address bits that the regions and requests use by default.
  localparam int unsigned AddrBitsDefault  = 32;
  // Results one request may give at most.
  localparam int unsigned MaxChunksDefault = 12;
  // Entries of the request queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Register file geometry: seven 64-bit registers at 8-byte strides.
  localparam int unsigned RegAddrBits = 6;
  localparam int unsigned RegDataBits = 64;

  typedef enum logic [2:0] {
    REG_TEXT_BOUNDS      = 3'd0,
    REG_DATA_BOUNDS      = 3'd1,
    REG_STACK_BOUNDS     = 3'd2,
    REG_EXEC_DATA_BOUNDS = 3'd3,
    REG_EXEC_OFFSETS     = 3'd4,
    REG_CORE_OFFSETS     = 3'd5,
    REG_IMAGES_PRESENT   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    SRC_HOLE = 2'd0,
    SRC_CORE = 2'd1,
    SRC_EXEC = 2'd2
  } source_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXEC_MISSING = 2'd1,
    ST_CORE_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] start_address;
    logic [31:0] request_length;
  } req_t;

  typedef struct packed {
    logic [31:0] chunk_address;
    logic [31:0] buffer_offset;
    logic [31:0] chunk_length;
    source_e     source;
    logic [31:0] file_offset;
    status_e     status;
    logic        last_chunk;
  } res_t;

  // Configuration as seen by the chunking engine.
  typedef struct packed {
    logic [63:0] text_bounds;
    logic [63:0] data_bounds;
    logic [63:0] stack_bounds;
    logic [63:0] exec_data_bounds;
    logic [63:0] exec_offsets;
    logic [63:0] core_offsets;
    logic [1:0]  images_present;
  } cfg_t;

endpackage

// ===== rtl/segment_request_splitter_core.sv =====
`timescale 1ns / 1ps
// Steps: the chunking engine takes each request from the queue in its idle
// state, then passes each chunk through the compare, select and emit states,
// and returns to idle after the last chunk of the request.
// Reset: asynchronous, active low; the control and configuration registers
// clear to zero and the queue empties; the datapath registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
// Structure. The front takes a transaction whenever the request queue has room
// and drops empty requests. The queue decouples the front from the back, so new
// requests are taken while earlier ones are still being cut into chunks. The
// back walks one request at a time: it compares the current address with all
// eight region bounds, resolves the region by fixed priority (including the
// nearest-bound hole for an address that matches no region), then clips the
// chunk to the remaining length and emits it from an output register.
//
// Users write configuration through the APB port only while idle (not enforced).
module segment_request_splitter_core import ssplit_pkg::*; #(
  parameter int unsigned AddrBits   = AddrBitsDefault,
  parameter int unsigned MaxChunks  = MaxChunksDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  req_t                   req_i,
  output logic                   res_valid_o,
  output res_t                   res_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RegAddrBits-1:0] paddr,
  input  logic [RegDataBits-1:0] pwdata,
  output logic [RegDataBits-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_empty;
  req_t q_wdata, q_rdata;

  // Every APB access completes in its first access cycle.
  assign pready = 1'b1;

  ssplit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  ssplit_front #(
    .AddrBits (AddrBits)
  ) u_front (
    .start_i  (start),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  ssplit_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ssplit_back #(
    .AddrBits  (AddrBits),
    .MaxChunks (MaxChunks)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A chunk never covers zero bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.chunk_length != '0))
    else $error("zero-length chunk emitted");

  // An error status always ends the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |-> res_o.last_chunk)
    else $error("error status without last_chunk");

  // A hole carries no file offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.source == SRC_HOLE)) |-> (res_o.file_offset == '0))
    else $error("hole chunk with nonzero file offset");

  // Each chunk passes the compare and select states first, so strobes never abut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobes in consecutive cycles");

endmodule

// ===== rtl/ssplit_regs.sv =====
`timescale 1ns / 1ps
module ssplit_regs import ssplit_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RegAddrBits-1:0] paddr,
  input  logic [RegDataBits-1:0] pwdata,
  output logic [RegDataBits-1:0] prdata,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_e'(paddr[RegAddrBits-1:3]);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TEXT_BOUNDS:      cfg_q.text_bounds      <= pwdata;
        REG_DATA_BOUNDS:      cfg_q.data_bounds      <= pwdata;
        REG_STACK_BOUNDS:     cfg_q.stack_bounds     <= pwdata;
        REG_EXEC_DATA_BOUNDS: cfg_q.exec_data_bounds <= pwdata;
        REG_EXEC_OFFSETS:     cfg_q.exec_offsets     <= pwdata;
        REG_CORE_OFFSETS:     cfg_q.core_offsets     <= pwdata;
        REG_IMAGES_PRESENT:   cfg_q.images_present   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEXT_BOUNDS:      prdata = cfg_q.text_bounds;
      REG_DATA_BOUNDS:      prdata = cfg_q.data_bounds;
      REG_STACK_BOUNDS:     prdata = cfg_q.stack_bounds;
      REG_EXEC_DATA_BOUNDS: prdata = cfg_q.exec_data_bounds;
      REG_EXEC_OFFSETS:     prdata = cfg_q.exec_offsets;
      REG_CORE_OFFSETS:     prdata = cfg_q.core_offsets;
      REG_IMAGES_PRESENT:   prdata = {{(RegDataBits-2){1'b0}}, cfg_q.images_present};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ssplit_queue.sv =====
`timescale 1ns / 1ps
module ssplit_queue import ssplit_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output req_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  req_t               mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CntBits'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrBits-1:0] bump(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + CntBits'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/ssplit_front.sv =====
`timescale 1ns / 1ps
module ssplit_front import ssplit_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic start_i,
  input  req_t req_i,
  input  logic q_full_i,
  output logic busy_o,
  output logic q_push_o,
  output req_t q_data_o
);

  localparam logic [31:0] AddrMask = 32'((64'd1 << AddrBits) - 64'd1);

  logic accept;

  // A request is taken whenever the queue has room; empty requests are
  // consumed here and never reach the chunking engine.
  assign busy_o   = q_full_i;
  assign accept   = start_i && !q_full_i;
  assign q_push_o = accept && (req_i.request_length != '0);

  assign q_data_o.start_address  = req_i.start_address & AddrMask;
  assign q_data_o.request_length = req_i.request_length;

endmodule

// ===== rtl/ssplit_back.sv =====
`timescale 1ns / 1ps
module ssplit_back import ssplit_pkg::*; #(
  parameter int unsigned AddrBits  = AddrBitsDefault,
  parameter int unsigned MaxChunks = MaxChunksDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_empty_i,
  input  req_t q_data_i,
  output logic q_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned NBits = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam logic [AddrBits:0] Space = {1'b1, {AddrBits{1'b0}}};

  // Order of the bounds in the compare vector.
  localparam int unsigned BTs = 0, BTe = 1, BDs = 2, BDe = 3;
  localparam int unsigned BSs = 4, BSe = 5, BXs = 6, BXe = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [AddrBits-1:0] addr_q;
  logic [31:0]         len_q, pos_q;
  logic [NBits-1:0]    n_q;
  logic [7:0]          lt_q;
  logic [AddrBits:0]   bound_q;
  source_e             src_q;
  logic [31:0]         fob_q;
  res_t                res_q;
  logic                res_valid_q;

  logic [AddrBits-1:0] bnd [8];
  logic [7:0]          lt_d;
  logic                core, exe, gap_lt;
  logic [AddrBits:0]   cand [8];
  logic [AddrBits:0]   m01, m23, m45, m67, m03, m47, mall;
  logic [AddrBits:0]   bound_d;
  source_e             src_d;
  logic [31:0]         fob_d;
  logic [AddrBits:0]   avail;
  logic [32:0]         avail_w;
  logic [31:0]         chunk;
  status_e             status;
  logic                last;

  function automatic logic [AddrBits:0] min2(input logic [AddrBits:0] a,
                                             input logic [AddrBits:0] b);
    return (a < b) ? a : b;
  endfunction

  assign core = cfg_i.images_present[0];
  assign exe  = cfg_i.images_present[1];

  assign bnd[BTs] = cfg_i.text_bounds[AddrBits-1:0];
  assign bnd[BTe] = cfg_i.text_bounds[32+AddrBits-1:32];
  assign bnd[BDs] = cfg_i.data_bounds[AddrBits-1:0];
  assign bnd[BDe] = cfg_i.data_bounds[32+AddrBits-1:32];
  assign bnd[BSs] = cfg_i.stack_bounds[AddrBits-1:0];
  assign bnd[BSe] = cfg_i.stack_bounds[32+AddrBits-1:32];
  assign bnd[BXs] = cfg_i.exec_data_bounds[AddrBits-1:0];
  assign bnd[BXe] = cfg_i.exec_data_bounds[32+AddrBits-1:32];

  // Compare stage: the address against every bound.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lt_d[k] = addr_q < bnd[k];
    end
  end

  // Nearest bound above the address, for an address that fits no region.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cand[k] = lt_q[k] ? {1'b0, bnd[k]} : Space;
    end
    m01  = min2(cand[0], cand[1]);
    m23  = min2(cand[2], cand[3]);
    m45  = min2(cand[4], cand[5]);
    m67  = min2(cand[6], cand[7]);
    m03  = min2(m01, m23);
    m47  = min2(m45, m67);
    mall = min2(m03, m47);
  end

  // Select stage: region rules in priority order.
  always_comb begin
    gap_lt  = core ? lt_q[BDe] : lt_q[BXe];
    bound_d = mall;
    src_d   = SRC_HOLE;
    fob_d   = '0;
    priority if (lt_q[BTs]) begin
      bound_d = {1'b0, bnd[BTs]};
    end else if (!lt_q[BTe] && lt_q[BDs]) begin
      bound_d = {1'b0, bnd[BDs]};
    end else if (!gap_lt && lt_q[BSs]) begin
      bound_d = {1'b0, bnd[BSs]};
    end else if (!lt_q[BSe] && (bnd[BSe] != '0)) begin
      bound_d = Space;
    end else if (!lt_q[BDs] && lt_q[BDe]) begin
      bound_d = {1'b0, bnd[BDe]};
      src_d   = SRC_CORE;
      fob_d   = cfg_i.core_offsets[31:0] - 32'(bnd[BDs]);
    end else if (!lt_q[BSs] && lt_q[BSe]) begin
      bound_d = {1'b0, bnd[BSe]};
      src_d   = SRC_CORE;
      fob_d   = cfg_i.core_offsets[63:32] - 32'(bnd[BSs]);
    end else if (!core && !lt_q[BXs] && lt_q[BXe]) begin
      bound_d = {1'b0, bnd[BXe]};
      src_d   = SRC_EXEC;
      fob_d   = cfg_i.exec_offsets[63:32] - 32'(bnd[BXs]);
    end else if (!lt_q[BTs] && lt_q[BTe]) begin
      bound_d = {1'b0, bnd[BTe]};
      src_d   = SRC_EXEC;
      fob_d   = cfg_i.exec_offsets[31:0] - 32'(bnd[BTs]);
    end else begin
      bound_d = mall;
    end
  end

  // Emit stage: clip to the remaining length and judge the image.
  always_comb begin
    avail   = bound_q - {1'b0, addr_q};
    avail_w = 33'(avail);
    chunk   = ({1'b0, len_q} < avail_w) ? len_q : avail_w[31:0];
    if (src_q == SRC_CORE && !core) begin
      status = ST_CORE_MISSING;
    end else if (src_q == SRC_EXEC && !exe) begin
      status = ST_EXEC_MISSING;
    end else begin
      status = ST_OK;
    end
    last = (status != ST_OK) || (chunk == len_q) || (n_q == NBits'(MaxChunks - 1));
  end

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            addr_q  <= q_data_i.start_address[AddrBits-1:0];
            len_q   <= q_data_i.request_length;
            pos_q   <= '0;
            n_q     <= '0;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          lt_q    <= lt_d;
          state_q <= S_SEL;
        end
        S_SEL: begin
          bound_q <= bound_d;
          src_q   <= src_d;
          fob_q   <= fob_d;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          res_valid_q         <= 1'b1;
          res_q.chunk_address <= 32'(addr_q);
          res_q.buffer_offset <= pos_q;
          res_q.chunk_length  <= chunk;
          res_q.source        <= src_q;
          res_q.file_offset   <= (src_q == SRC_HOLE) ? '0 : (32'(addr_q) + fob_q);
          res_q.status        <= status;
          res_q.last_chunk    <= last;
          addr_q              <= addr_q + chunk[AddrBits-1:0];
          pos_q               <= pos_q + chunk;
          len_q               <= len_q - chunk;
          n_q                 <= n_q + NBits'(1);
          state_q             <= last ? S_IDLE : S_CMP;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
